FILE: hdl/dda_pkg.sv
package dda_pkg;

    localparam int COORD_BITS  = 11;
    localparam int FRAC_BITS   = 16;
    localparam int COLOR_BITS  = 24;
    localparam int STEP_BITS   = FRAC_BITS + 2;
    localparam int POS_BITS    = COORD_BITS + FRAC_BITS + 2;
    localparam int DIV_CNT_BITS = $clog2(FRAC_BITS + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    // classified command, as it sits in the queue
    typedef struct packed {
        logic                  kind;
        logic [COORD_BITS-1:0] x_start;
        logic [COORD_BITS-1:0] y_start;
        logic [COORD_BITS-1:0] abs_x;
        logic [COORD_BITS-1:0] abs_y;
        logic                  neg_x;
        logic                  neg_y;
        logic [COORD_BITS-1:0] len;
    } entry_t;

endpackage

FILE: hdl/dda_ifs.sv
interface dda_cmd_if;
    import dda_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  kind;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;

    modport source (output valid, kind, x_start, y_start, x_end, y_end, input ready);
    modport sink   (input valid, kind, x_start, y_start, x_end, y_end, output ready);
endinterface

interface dda_pixel_if;
    import dda_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [COLOR_BITS-1:0] pixel_color;
    logic                  last_pixel;

    modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel, input ready);
    modport sink   (input valid, pixel_x, pixel_y, pixel_color, last_pixel, output ready);
endinterface

FILE: hdl/dda_front.sv
module dda_front (
    input  logic            clk,
    input  logic            rst_n,
    dda_cmd_if.sink         cmd,
    output dda_pkg::entry_t head,
    output logic            head_valid,
    input  logic            pop
);
    import dda_pkg::*;

    entry_t                slot_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0]  count_reg, count_next;

    logic [COORD_BITS:0]   dx, dy, mag_x, mag_y;
    logic [COORD_BITS-1:0] abs_x, abs_y;
    entry_t                incoming;
    logic                  push;
    logic                  do_pop;

    // endpoint differences and major length
    always_comb
    begin
        dx    = {1'b0, cmd.x_end} - {1'b0, cmd.x_start};
        dy    = {1'b0, cmd.y_end} - {1'b0, cmd.y_start};
        mag_x = dx[COORD_BITS] ? (~dx + 1'b1) : dx;
        mag_y = dy[COORD_BITS] ? (~dy + 1'b1) : dy;
        abs_x = mag_x[COORD_BITS-1:0];
        abs_y = mag_y[COORD_BITS-1:0];

        incoming.kind    = cmd.kind;
        incoming.x_start = cmd.x_start;
        incoming.y_start = cmd.y_start;
        incoming.abs_x   = abs_x;
        incoming.abs_y   = abs_y;
        incoming.neg_x   = dx[COORD_BITS];
        incoming.neg_y   = dy[COORD_BITS];
        incoming.len     = (abs_x > abs_y) ? abs_x : abs_y;
    end

    assign cmd.ready  = (count_reg != QCNT_BITS'(QUEUE_DEPTH));
    assign push       = cmd.valid && cmd.ready;
    assign head_valid = (count_reg != '0);
    assign do_pop     = pop && head_valid;
    assign head       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= incoming;
        end
    end

endmodule

FILE: hdl/dda_back.sv
module dda_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  dda_pkg::entry_t                head,
    input  logic                           head_valid,
    output logic                           pop,
    input  logic [dda_pkg::COLOR_BITS-1:0] color,
    dda_pixel_if.source                    pixel
);
    import dda_pkg::*;

    typedef enum logic [1:0] {
        ST_READY = 2'b01,
        ST_DIV   = 2'b10
    } state_t;

    localparam logic [POS_BITS-1:0]     HALF_POS = POS_BITS'(1) << (FRAC_BITS - 1);
    localparam logic [DIV_CNT_BITS-1:0] CNT_LAST = DIV_CNT_BITS'(FRAC_BITS);

    state_t                  state_reg, state_next;
    logic                    busy_reg, busy_next;
    logic [COORD_BITS-1:0]   left_reg, left_next;
    logic [POS_BITS-1:0]     pos_x_reg, pos_x_next, pos_y_reg, pos_y_next;
    logic [STEP_BITS-1:0]    step_x_reg, step_x_next, step_y_reg, step_y_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [COORD_BITS:0]     rem_x_reg, rem_x_next, rem_y_reg, rem_y_next;
    logic [FRAC_BITS:0]      quo_x_reg, quo_x_next, quo_y_reg, quo_y_next;
    logic [COORD_BITS-1:0]   len_reg, len_next;
    logic                    neg_x_reg, neg_x_next, neg_y_reg, neg_y_next;
    logic [COORD_BITS-1:0]   xs_reg, xs_next, ys_reg, ys_next;

    logic                    out_valid_reg, out_valid_next;
    logic [COORD_BITS-1:0]   out_x_reg, out_x_next, out_y_reg, out_y_next;
    logic [COLOR_BITS-1:0]   out_color_reg, out_color_next;
    logic                    out_last_reg, out_last_next;

    logic                    slot_free, is_step, emit, load;
    logic                    ge_x, ge_y;
    logic [COORD_BITS:0]     diff_x, diff_y;
    logic [FRAC_BITS:0]      qx_new, qy_new;
    logic [STEP_BITS-1:0]    mag_x, mag_y;
    logic [POS_BITS-1:0]     half_x, half_y;

    function automatic logic [COORD_BITS-1:0] to_pixel(input logic [POS_BITS-1:0] pos);
        logic [COORD_BITS:0] whole;
        whole = pos[POS_BITS-2:FRAC_BITS];
        if (pos[POS_BITS-1])
        begin
            return '0;
        end
        else if (whole[COORD_BITS])
        begin
            return '1;
        end
        else
        begin
            return whole[COORD_BITS-1:0];
        end
    endfunction

    function automatic logic [POS_BITS-1:0] sext_step(input logic [STEP_BITS-1:0] s);
        return {{(POS_BITS - STEP_BITS){s[STEP_BITS-1]}}, s};
    endfunction

    assign slot_free = !out_valid_reg || pixel.ready;
    assign is_step   = (head.kind == KIND_STEP);
    assign pop       = (state_reg == ST_READY) && head_valid
                       && (!is_step || !busy_reg || slot_free);
    assign emit      = pop && is_step && busy_reg;
    assign load      = pop && !is_step;

    // one quotient bit per cycle for both axes; the remainder after each subtract stays below len
    always_comb
    begin
        ge_x   = (rem_x_reg >= {1'b0, len_reg});
        ge_y   = (rem_y_reg >= {1'b0, len_reg});
        diff_x = ge_x ? (rem_x_reg - {1'b0, len_reg}) : rem_x_reg;
        diff_y = ge_y ? (rem_y_reg - {1'b0, len_reg}) : rem_y_reg;
        qx_new = {quo_x_reg[FRAC_BITS-1:0], ge_x};
        qy_new = {quo_y_reg[FRAC_BITS-1:0], ge_y};
        mag_x  = {1'b0, qx_new};
        mag_y  = {1'b0, qy_new};
        half_x = (qx_new == '0) ? '0 : (neg_x_reg ? (~HALF_POS + 1'b1) : HALF_POS);
        half_y = (qy_new == '0) ? '0 : (neg_y_reg ? (~HALF_POS + 1'b1) : HALF_POS);
    end

    always_comb
    begin
        state_next     = state_reg;
        busy_next      = busy_reg;
        left_next      = left_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        step_x_next    = step_x_reg;
        step_y_next    = step_y_reg;
        cnt_next       = cnt_reg;
        rem_x_next     = rem_x_reg;
        rem_y_next     = rem_y_reg;
        quo_x_next     = quo_x_reg;
        quo_y_next     = quo_y_reg;
        len_next       = len_reg;
        neg_x_next     = neg_x_reg;
        neg_y_next     = neg_y_reg;
        xs_next        = xs_reg;
        ys_next        = ys_reg;
        out_valid_next = pixel.ready ? 1'b0 : out_valid_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_color_next = out_color_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            ST_READY:
            begin
                if (load)
                begin
                    if (head.len == '0)
                    begin
                        // zero length: one pixel, no half-pixel offset
                        step_x_next = '0;
                        step_y_next = '0;
                        pos_x_next  = {2'b00, head.x_start, {FRAC_BITS{1'b0}}};
                        pos_y_next  = {2'b00, head.y_start, {FRAC_BITS{1'b0}}};
                        left_next   = '0;
                        busy_next   = 1'b1;
                    end
                    else
                    begin
                        xs_next    = head.x_start;
                        ys_next    = head.y_start;
                        neg_x_next = head.neg_x;
                        neg_y_next = head.neg_y;
                        len_next   = head.len;
                        rem_x_next = {1'b0, head.abs_x};
                        rem_y_next = {1'b0, head.abs_y};
                        quo_x_next = '0;
                        quo_y_next = '0;
                        cnt_next   = '0;
                        state_next = ST_DIV;
                    end
                end
                else if (emit)
                begin
                    out_valid_next = 1'b1;
                    out_x_next     = to_pixel(pos_x_reg);
                    out_y_next     = to_pixel(pos_y_reg);
                    out_color_next = color;
                    out_last_next  = (left_reg == '0);
                    if (left_reg == '0)
                    begin
                        busy_next = 1'b0;
                    end
                    else
                    begin
                        left_next  = left_reg - 1'b1;
                        pos_x_next = pos_x_reg + sext_step(step_x_reg);
                        pos_y_next = pos_y_reg + sext_step(step_y_reg);
                    end
                end
            end
            ST_DIV:
            begin
                rem_x_next = {diff_x[COORD_BITS-1:0], 1'b0};
                rem_y_next = {diff_y[COORD_BITS-1:0], 1'b0};
                quo_x_next = qx_new;
                quo_y_next = qy_new;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    step_x_next = neg_x_reg ? (~mag_x + 1'b1) : mag_x;
                    step_y_next = neg_y_reg ? (~mag_y + 1'b1) : mag_y;
                    pos_x_next  = {2'b00, xs_reg, {FRAC_BITS{1'b0}}} + half_x;
                    pos_y_next  = {2'b00, ys_reg, {FRAC_BITS{1'b0}}} + half_y;
                    left_next   = len_reg;
                    busy_next   = 1'b1;
                    state_next  = ST_READY;
                end
            end
            default:
            begin
                state_next = ST_READY;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_READY;
            busy_reg      <= 1'b0;
            left_reg      <= '0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            step_x_reg    <= '0;
            step_y_reg    <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            busy_reg      <= busy_next;
            left_reg      <= left_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            step_x_reg    <= step_x_next;
            step_y_reg    <= step_y_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_x_reg     <= rem_x_next;
        rem_y_reg     <= rem_y_next;
        quo_x_reg     <= quo_x_next;
        quo_y_reg     <= quo_y_next;
        len_reg       <= len_next;
        neg_x_reg     <= neg_x_next;
        neg_y_reg     <= neg_y_next;
        xs_reg        <= xs_next;
        ys_reg        <= ys_next;
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
        out_color_reg <= out_color_next;
        out_last_reg  <= out_last_next;
    end

    assign pixel.valid       = out_valid_reg;
    assign pixel.pixel_x     = out_x_reg;
    assign pixel.pixel_y     = out_y_reg;
    assign pixel.pixel_color = out_color_reg;
    assign pixel.last_pixel  = out_last_reg;

endmodule

FILE: hdl/dda_line_rasterizer.sv
// channel   dir  beat contents
// cmd       in   kind, x_start, y_start, x_end, y_end (kind 0 load, 1 step)
// pixel     out  pixel_x, pixel_y, pixel_color, last_pixel
// color     in   color_we / color_wdata, line color register, no read-back
//
// in a segment, a step beat gives one pixel per cycle while output drains
// a load with nonzero length is popped, then holds the back end in
// the restoring divider, which works both axes under one counter
// a two-entry queue lets cmd beats be taken while the divider runs
// or a pixel waits on pixel.ready
// rst_n clears the queue, the segment state and the color register
module dda_line_rasterizer (
    input  logic                           clk,
    input  logic                           rst_n,
    dda_cmd_if.sink                        cmd,
    dda_pixel_if.source                    pixel,
    input  logic                           color_we,
    input  logic [dda_pkg::COLOR_BITS-1:0] color_wdata
);
    import dda_pkg::*;

    logic [COLOR_BITS-1:0] color_reg;
    entry_t                head;
    logic                  head_valid;
    logic                  pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg <= '0;
        end
        else if (color_we)
        begin
            color_reg <= color_wdata;
        end
    end

    dda_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop)
    );

    dda_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .color      (color_reg),
        .pixel      (pixel)
    );

endmodule

FILE: hdl/dda_checker.sv
module dda_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           cmd_valid,
    input logic                           cmd_ready,
    input logic                           pix_valid,
    input logic                           pix_ready,
    input logic [dda_pkg::COORD_BITS-1:0] pix_x,
    input logic [dda_pkg::COORD_BITS-1:0] pix_y,
    input logic                           pix_last
);
    import dda_pkg::*;

    // a held pixel beat keeps its coordinates and last flag
    a_pixel_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && !pix_ready |=> pix_valid && $stable(pix_x) && $stable(pix_y)
                                    && $stable(pix_last))
        else $error("pixel beat changed while stalled");

    // the queue only fills by taking a beat
    a_fill_by_accept: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(cmd_ready) |-> $past(cmd_valid))
        else $error("cmd ready dropped with no beat taken");

    // nothing is offered right out of reset
    a_quiet_after_reset: assert property (@(posedge clk)
        !$past(rst_n) |-> !pix_valid)
        else $error("pixel valid right after reset");

    // a rising pixel valid needs rst_n high at an earlier sample too
    a_no_early_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pix_valid) |-> $past(rst_n, 2))
        else $error("pixel appeared too soon after reset");

endmodule

bind dda_line_rasterizer dda_checker u_dda_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .pix_valid (pixel.valid),
    .pix_ready (pixel.ready),
    .pix_x     (pixel.pixel_x),
    .pix_y     (pixel.pixel_y),
    .pix_last  (pixel.last_pixel)
);
